// File: hdl/pli_pkg.sv
package pli_pkg;

  // payload and size limits
  localparam int VAL_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int POS_W     = 5;
  localparam int IDX_OUT_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int STAT_W    = 2;
  localparam int DEPTH_DEF = 16;
  localparam int DEPTH_MAX = 64;

  // compare width wide enough for any count and any position
  localparam int CMP_W = $clog2(DEPTH_MAX + 1);

  // operation codes on the input channel
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  // shift commands broadcast along the cell chain
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] cnt;
  } cell_cmd_t;

endpackage

// File: hdl/pli_cell.sv
module pli_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  pli_pkg::cell_cmd_t       cmd,
  input  logic [pli_pkg::VAL_W-1:0] left_val,
  input  logic [pli_pkg::VAL_W-1:0] right_val,
  input  logic [pli_pkg::VAL_W-1:0] head_val,
  input  logic [pli_pkg::VAL_W-1:0] ins_val,
  output logic [pli_pkg::VAL_W-1:0] val
);
  import pli_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] MY_NEXT = CMP_W'(IDX + 1);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // pick from self, neighbors, the head or the new value
  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      OP_INS: begin
        if (MY_IDX == cmd.pos) begin
          val_nxt = ins_val;
        end else if (MY_IDX > cmd.pos && MY_IDX <= cmd.cnt) begin
          val_nxt = left_val;
        end
      end
      OP_REM: begin
        if (MY_IDX >= cmd.pos && MY_NEXT < cmd.cnt) begin
          val_nxt = right_val;
        end
      end
      OP_ROT: begin
        if (MY_NEXT < cmd.cnt) begin
          val_nxt = right_val;
        end else if (MY_NEXT == cmd.cnt) begin
          val_nxt = head_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: hdl/positional_list_insert_remove_top.sv
// Positional list: an ordered list of up to DEPTH signed 32-bit entries.
// Input channel (in_valid / in_stall): in_func selects insert at in_pos,
// remove at in_pos, or dump; in_value is the entry to insert.
// Result channel (out_valid / out_stall): one item per insert, remove,
// unused code or dump of an empty list; a dump of n entries gives n items,
// head first, with out_last on the final one. out_status reports range,
// full and empty errors; out_entry_count is the count after the operation.
// A result is registered and shows in the cycle after its item is taken;
// for a dump, dump_r is set first and the first entry is then loaded into
// the result register. Insert and remove are done as the item is taken, so
// one item per cycle is sustained while the receiver does not stall and no
// dump is running; the affected cells of the chain shift together.
// A dump holds the input until its last entry is emitted: the chain rotates
// one place per emitted entry and ends where it started.
// Reset clears the list to empty and drops any pending result. When the
// receiver stalls, the result register holds, a dump pauses, and in_stall
// rises until the result register can be refilled.
module positional_list_insert_remove_top #(
  parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pli_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [pli_pkg::VAL_W-1:0]   in_value,
  input  logic [pli_pkg::POS_W-1:0]          in_pos,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pli_pkg::VAL_W-1:0]   out_item_value,
  output logic [pli_pkg::IDX_OUT_W-1:0]      out_item_index,
  output logic [pli_pkg::STAT_W-1:0]         out_status,
  output logic [pli_pkg::CNT_OUT_W-1:0]      out_entry_count,
  output logic                               out_last
);
  import pli_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             dump_r;
  logic             dump_nxt;
  logic [CW-1:0]    dump_idx_r;
  logic [CW-1:0]    dump_idx_nxt;
  logic             out_valid_r;

  logic [VAL_W-1:0]     item_value_r;
  logic [IDX_OUT_W-1:0] item_index_r;
  logic [STAT_W-1:0]    status_r;
  logic [CNT_OUT_W-1:0] entry_count_r;
  logic                 last_r;

  logic             out_free;
  logic             in_acc;
  logic             single_load;
  logic             dump_emit;
  logic             emit_last;
  logic [STAT_W-1:0] acc_status;
  logic             acc_dump;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  cell_cmd_t        cmd;
  logic [VAL_W-1:0] vals [DEPTH];

  // handshake
  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = dump_r | ~out_free;
  assign in_acc    = in_valid & ~in_stall;
  assign dump_emit = dump_r & out_free;
  assign emit_last = (CMP_W'(dump_idx_r) + CMP_W'(1)) == cnt_ext;

  assign cnt_ext = CMP_W'(count_r);
  assign pos_ext = CMP_W'(in_pos);

  // decode an accepted item into status, count and chain command
  always_comb begin
    acc_status = ST_OK;
    acc_dump   = 1'b0;
    count_nxt  = count_r;
    cmd.op     = OP_HOLD;
    cmd.pos    = pos_ext;
    cmd.cnt    = cnt_ext;
    if (in_acc) begin
      unique case (in_func)
        FN_INSERT: begin
          if (pos_ext > cnt_ext) begin
            acc_status = ST_RANGE;
          end else if (cnt_ext >= CMP_W'(DEPTH)) begin
            acc_status = ST_FULL;
          end else begin
            cmd.op    = OP_INS;
            count_nxt = count_r + CW'(1);
          end
        end
        FN_REMOVE: begin
          if (count_r == '0) begin
            acc_status = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            acc_status = ST_RANGE;
          end else begin
            cmd.op    = OP_REM;
            count_nxt = count_r - CW'(1);
          end
        end
        FN_DUMP: begin
          if (count_r == '0) begin
            acc_status = ST_EMPTY;
          end else begin
            acc_dump = 1'b1;
          end
        end
        default: acc_status = ST_OK;
      endcase
    end else if (dump_emit) begin
      cmd.op = OP_ROT;
    end
  end

  assign single_load = in_acc & ~acc_dump;

  // dump sequencing
  always_comb begin
    dump_nxt     = dump_r;
    dump_idx_nxt = dump_idx_r;
    if (in_acc && acc_dump) begin
      dump_nxt     = 1'b1;
      dump_idx_nxt = '0;
    end else if (dump_emit) begin
      if (emit_last) begin
        dump_nxt     = 1'b0;
        dump_idx_nxt = '0;
      end else begin
        dump_idx_nxt = dump_idx_r + CW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dump_r      <= 1'b0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dump_r      <= dump_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= single_load | dump_emit | (out_valid_r & out_stall);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (single_load) begin
      item_value_r  <= '0;
      item_index_r  <= '0;
      status_r      <= acc_status;
      entry_count_r <= CNT_OUT_W'(count_nxt);
      last_r        <= 1'b1;
    end else if (dump_emit) begin
      item_value_r  <= vals[0];
      item_index_r  <= IDX_OUT_W'(dump_idx_r);
      status_r      <= ST_OK;
      entry_count_r <= CNT_OUT_W'(count_r);
      last_r        <= emit_last;
    end
  end

  // chain of entry cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = vals[i];
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end
    pli_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (vals[0]),
      .ins_val   (in_value),
      .val       (vals[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_item_value  = item_value_r;
  assign out_item_index  = item_index_r;
  assign out_status      = status_r;
  assign out_entry_count = entry_count_r;
  assign out_last        = last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("entry count above depth");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dump_r) |-> count_r != '0)
    else $error("dump started on empty list");

  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (dump_emit && emit_last) |=> !dump_r)
    else $error("dump did not end after last entry");

  a_nonlast_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> dump_r)
    else $error("non-final item outside a dump");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(in_acc))
    else $error("count changed without an accepted item");

endmodule

// File: bench/tb_positional_list_insert_remove_top.sv
`timescale 1ns / 100ps

module tb_positional_list_insert_remove_top;
  import pli_pkg::*;

  // the block has no name for the spare operation code
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 350;
  localparam int CALM_ITEMS   = 40;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 30;

  typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} op_mix_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [IDX_OUT_W-1:0]    index;
    logic [STAT_W-1:0]       status;
    logic [CNT_OUT_W-1:0]    count;
    logic                    last;
  } list_result_t;

  // shadow copy of the list plus the results it still owes
  class list_shadow_t;
    logic signed [VAL_W-1:0] cells [DEPTH_DEF];
    int n_cells;
    list_result_t due_results [$];
    int err_cnt;
    int n_checked;
    int n_ins, n_rem, n_dump, n_unused;
    int n_full, n_empty, n_range;

    function new();
      n_cells = 0;
      err_cnt = 0;
      n_checked = 0;
      n_ins = 0; n_rem = 0; n_dump = 0; n_unused = 0;
      n_full = 0; n_empty = 0; n_range = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void queue_result(logic signed [VAL_W-1:0] v, int idx,
                               logic [STAT_W-1:0] st, logic is_last);
      list_result_t r;
      r.value  = v;
      r.index  = IDX_OUT_W'(idx);
      r.status = st;
      r.count  = CNT_OUT_W'(n_cells);
      r.last   = is_last;
      due_results.insert(due_results.size(), r);
      if (st == ST_FULL) n_full++;
      if (st == ST_EMPTY) n_empty++;
      if (st == ST_RANGE) n_range++;
    endfunction

    // predict the effect of one accepted item
    function void apply_op(logic [FUNC_W-1:0] fn, logic signed [VAL_W-1:0] v,
                           logic [POS_W-1:0] p);
      logic [STAT_W-1:0] st;
      st = ST_OK;
      case (fn)
        FN_INSERT: begin
          n_ins++;
          if (int'(p) > n_cells) begin
            st = ST_RANGE;
          end else if (n_cells >= DEPTH_DEF) begin
            st = ST_FULL;
          end else begin
            for (int i = n_cells; i > int'(p); i--) cells[i] = cells[i-1];
            cells[p] = v;
            n_cells++;
          end
        end
        FN_REMOVE: begin
          n_rem++;
          if (n_cells == 0) begin
            st = ST_EMPTY;
          end else if (int'(p) >= n_cells) begin
            st = ST_RANGE;
          end else begin
            for (int i = int'(p); i + 1 < n_cells; i++) cells[i] = cells[i+1];
            n_cells--;
          end
        end
        FN_DUMP: begin
          n_dump++;
          if (n_cells == 0) begin
            st = ST_EMPTY;
          end else begin
            for (int i = 0; i < n_cells; i++)
              queue_result(cells[i], i, ST_OK, (i + 1 == n_cells));
            return;
          end
        end
        default: n_unused++;
      endcase
      queue_result('0, 0, st, 1'b1);
    endfunction

    task report(string msg);
      err_cnt++;
      if (err_cnt <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // compare one accepted result with the oldest prediction
    task check_result(list_result_t got);
      list_result_t want;
      if (due_results.size() == 0) begin
        report("result item with nothing outstanding");
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (got.value !== want.value)
        report($sformatf("item_value %0d, want %0d", got.value, want.value));
      if (got.index !== want.index)
        report($sformatf("item_index %0d, want %0d", got.index, want.index));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.count !== want.count)
        report($sformatf("entry_count %0d, want %0d", got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [FUNC_W-1:0]       in_func = FN_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0]        in_pos = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_item_value;
  logic [IDX_OUT_W-1:0]    out_item_index;
  logic [STAT_W-1:0]       out_status;
  logic [CNT_OUT_W-1:0]    out_entry_count;
  logic                    out_last;

  list_shadow_t shadow = new();
  bit idle_on = 1'b0;
  bit hold_req = 1'b0;
  int cycle_cnt = 0;

  positional_list_insert_remove_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_pos          (in_pos),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item_value  (out_item_value),
    .out_item_index  (out_item_index),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // give up after a generous number of cycles
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side: check accepted items, stall in bursts or one long hold
  initial begin : result_side
    int burst_left;
    int hold_left;
    list_result_t got;
    burst_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.value  = out_item_value;
        got.index  = out_item_index;
        got.status = out_status;
        got.count  = out_entry_count;
        got.last   = out_last;
        shadow.check_result(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one item and wait until the block takes it
  task automatic send_item(input logic [FUNC_W-1:0] fn,
                           input logic signed [VAL_W-1:0] v,
                           input logic [POS_W-1:0] p);
    in_valid <= 1'b1;
    in_func  <= fn;
    in_value <= v;
    in_pos   <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.apply_op(fn, v, p);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  // random item, mostly legal positions, weighted toward one kind of op
  task automatic send_random(input op_mix_t mix);
    logic [FUNC_W-1:0] fn;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    int r;
    int cnt;
    cnt = shadow.n_cells;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  fn = (r < 72) ? FN_INSERT : (r < 84) ? FN_REMOVE :
                      (r < 97) ? FN_DUMP : FN_UNUSED;
      MIX_DRAIN: fn = (r < 20) ? FN_INSERT : (r < 84) ? FN_REMOVE :
                      (r < 97) ? FN_DUMP : FN_UNUSED;
      default:   fn = (r < 44) ? FN_INSERT : (r < 84) ? FN_REMOVE :
                      (r < 97) ? FN_DUMP : FN_UNUSED;
    endcase
    r = $urandom_range(0, 11);
    if (r == 0)
      p = POS_W'($urandom_range(0, 31));
    else if (r == 1)
      p = POS_W'(cnt);
    else if (r == 2)
      p = '0;
    else if (fn == FN_INSERT)
      p = POS_W'($urandom_range(0, cnt));
    else
      p = (cnt > 0) ? POS_W'($urandom_range(0, cnt - 1)) : '0;
    r = $urandom_range(0, 9);
    case (r)
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2: v = '0;
      3: v = -32'sd1;
      default: v = $urandom;
    endcase
    send_item(fn, v, p);
    if (idle_on && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 13));
  endtask

  initial begin : stimulus
    int sent;
    int phase_no;
    int n;
    op_mix_t mix;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners and out-of-range positions
    send_item(FN_REMOVE, 32'sd5, 5'd0);
    send_item(FN_DUMP, -32'sd1, 5'd31);
    send_item(FN_INSERT, 32'sd9, 5'd1);
    send_item(FN_INSERT, -32'sd1, 5'd31);
    send_item(FN_UNUSED, 32'sd1, 5'd0);
    // build a short list with the value extremes: head, tail and middle
    send_item(FN_INSERT, 32'sh7fffffff, 5'd0);
    send_item(FN_INSERT, 32'sh80000000, 5'd1);
    send_item(FN_INSERT, -32'sd1, 5'd0);
    send_item(FN_INSERT, 32'sd0, 5'd1);
    send_item(FN_INSERT, 32'sh5a5a5a5a, 5'd4);
    send_item(FN_DUMP, 32'sd0, 5'd0);
    // removes: past the end, middle, head, tail
    send_item(FN_REMOVE, 32'sd0, 5'd5);
    send_item(FN_REMOVE, 32'sd0, 5'd16);
    send_item(FN_REMOVE, 32'sd0, 5'd2);
    send_item(FN_REMOVE, 32'sd0, 5'd0);
    send_item(FN_REMOVE, 32'sd0, 5'd2);
    send_item(FN_UNUSED, 32'sh7fffffff, 5'd31);
    send_item(FN_DUMP, 32'sd0, 5'd0);

    // random phases: fill, drain and even mixes, with and without idling
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS - CALM_ITEMS) begin
      idle_on = (phase_no % 4) != 3 && phase_no != 2;
      if (phase_no == 2) hold_req = 1'b1;
      if (phase_no == 4) drain_results();
      case (phase_no % 3)
        0: mix = MIX_FILL;
        1: mix = MIX_DRAIN;
        default: mix = ($urandom_range(0, 1) == 0) ? MIX_EVEN : MIX_FILL;
      endcase
      n = $urandom_range(20, 40);
      repeat (n) send_random(mix);
      sent += n;
      phase_no++;
    end

    // last stretch at full rate
    idle_on = 1'b0;
    repeat (CALM_ITEMS) send_random(MIX_EVEN);

    drain_results();
    repeat (20) @(posedge clk);

    $display("run: %0d inserts, %0d removes, %0d dumps, %0d spare-code items, %0d results",
             shadow.n_ins, shadow.n_rem, shadow.n_dump, shadow.n_unused,
             shadow.n_checked);
    $display("run: list full %0d times, empty %0d times, bad position %0d times",
             shadow.n_full, shadow.n_empty, shadow.n_range);
    if (shadow.err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
